// ----- rtl/tsra_pkg.sv -----
`timescale 1ns / 1ps

package tsra_pkg;

	localparam int unsigned FrameBits = 16;
	localparam int unsigned CodeBits  = 12;
	localparam int unsigned CodeShift = 3;
	localparam int unsigned OpenBit   = 2;
	localparam logic [4:0]  MaxSamples = 5'd16;
	localparam logic [11:0] CodeMax    = 12'hFFF;

	localparam logic [9:0]  CsSetupReset    = 10'd10;
	localparam logic [9:0]  HalfBitReset    = 10'd50;
	localparam logic [19:0] SampleGapReset  = 20'd100000;
	localparam logic [4:0]  SampleCountReset = 5'd1;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SETUP,
		PH_LOW,
		PH_HIGH,
		PH_GAP
	} phase_t;

	typedef enum logic [1:0] {
		CTL_IDLE,
		CTL_DIV,
		CTL_OUT
	} ctl_t;

	typedef enum logic [1:0] {
		REG_CS_SETUP,
		REG_HALF_BIT,
		REG_SAMPLE_GAP,
		REG_SAMPLE_COUNT
	} cfg_reg_t;

	typedef struct packed {
		logic start_req;
		logic data_in;
	} in_item_t;

	typedef struct packed {
		logic        select_n;
		logic        clock_level;
		logic        done_res;
		logic [11:0] temperature_code;
		logic        open_sensor;
		logic        busy_res;
	} out_item_t;

endpackage

// ----- rtl/thermocouple_spi_read_averager.sv -----
`timescale 1ns / 1ps

// channel  direction  handshake              payload
// in       in         in_valid / in_ready    in_data (start_req, data_in), one tick per item
// out      out        out_valid / out_ready  out_data (pin levels, code, flags), one per tick
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a tick is accepted, then transferred to the output register once that register is free
// the tick that closes a reading runs the average through a
// restoring divider that retires one quotient bit per cycle over 16 bits
// the next tick is accepted while the previous result still sits in the output register
// arst_n clears the sequencer and loads the register defaults; cfg is always ready

module thermocouple_spi_read_averager (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  tsra_pkg::in_item_t    in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output tsra_pkg::out_item_t   out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [19:0]           cfg_data
);
	import tsra_pkg::*;

	// configuration
	logic [9:0]  cs_setup_q;
	logic [9:0]  half_bit_q;
	logic [19:0] gap_q;
	logic [4:0]  count_q;

	// sequencer state
	phase_t      phase_q, phase_d;
	logic [19:0] tick_q, tick_d, tick_inc;
	logic [3:0]  bit_q, bit_d;
	logic [15:0] frame_q, frame_d;
	logic [15:0] sum_q, sum_d;
	logic [4:0]  samples_q, samples_d;
	logic        open_q, open_d;
	logic        clkreg_q, clkreg_d;
	logic [11:0] held_q;

	// per-tick result
	logic        sel_d, clk_lvl_d, done_d, busy_d;
	logic        sel_q, clk_lvl_q, done_q, busy_q, res_open_q;

	logic [9:0]  half_eff;
	logic [4:0]  n_eff;

	// divider
	ctl_t        ctl_q, ctl_d;
	logic [15:0] quo_q;
	logic [4:0]  rem_q;
	logic [4:0]  div_d_q;
	logic [3:0]  div_cnt_q;
	logic [5:0]  trial;
	logic        trial_ge;
	logic        div_last;

	logic        accept;
	logic        load_out;
	logic        out_valid_q;
	out_item_t   out_q;

	assign cfg_ready = 1'b1;
	assign half_eff  = (half_bit_q == 10'd0) ? 10'd1 : half_bit_q;
	assign n_eff     = (count_q == 5'd0) ? 5'd1 :
	                   ((count_q > MaxSamples) ? MaxSamples : count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_setup_q <= CsSetupReset;
			half_bit_q <= HalfBitReset;
			gap_q      <= SampleGapReset;
			count_q    <= SampleCountReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CS_SETUP:     cs_setup_q <= cfg_data[9:0];
				REG_HALF_BIT:     half_bit_q <= cfg_data[9:0];
				REG_SAMPLE_GAP:   gap_q      <= cfg_data;
				REG_SAMPLE_COUNT: count_q    <= cfg_data[4:0];
				default:          ;
			endcase
		end
	end

	// one tick of the serial master
	always_comb begin
		phase_d   = phase_q;
		tick_d    = tick_q;
		bit_d     = bit_q;
		frame_d   = frame_q;
		sum_d     = sum_q;
		samples_d = samples_q;
		open_d    = open_q;
		clkreg_d  = clkreg_q;
		sel_d     = 1'b1;
		done_d    = 1'b0;
		busy_d    = 1'b0;

		if (phase_q == PH_IDLE && in_data.start_req) begin
			sum_d     = '0;
			samples_d = '0;
			open_d    = 1'b0;
			phase_d   = PH_SETUP;
			tick_d    = '0;
			if (cs_setup_q == 10'd0) begin
				phase_d  = PH_LOW;
				bit_d    = '0;
				frame_d  = '0;
				clkreg_d = 1'b0;
			end
		end

		clk_lvl_d = clkreg_d;
		tick_inc  = tick_d + 20'd1;

		unique case (phase_d)
			PH_IDLE: ;
			PH_SETUP: begin
				busy_d = 1'b1;
				sel_d  = 1'b0;
				tick_d = tick_inc;
				if (tick_inc >= {10'd0, cs_setup_q}) begin
					phase_d  = PH_LOW;
					tick_d   = '0;
					bit_d    = '0;
					frame_d  = '0;
					clkreg_d = 1'b0;
				end
			end
			PH_LOW: begin
				busy_d    = 1'b1;
				sel_d     = 1'b0;
				clk_lvl_d = 1'b0;
				tick_d    = tick_inc;
				if (tick_inc >= {10'd0, half_eff}) begin
					frame_d  = {frame_d[14:0], in_data.data_in};
					tick_d   = '0;
					phase_d  = PH_HIGH;
					clkreg_d = 1'b1;
				end
			end
			PH_HIGH: begin
				busy_d    = 1'b1;
				sel_d     = 1'b0;
				clk_lvl_d = 1'b1;
				tick_d    = tick_inc;
				if (tick_inc >= {10'd0, half_eff}) begin
					tick_d = '0;
					if (bit_d == 4'(FrameBits - 1)) begin
						if (frame_d[OpenBit]) open_d = 1'b1;
						sum_d     = sum_d + {4'd0, frame_d[CodeShift +: CodeBits]};
						samples_d = samples_d + 5'd1;
						if (samples_d >= n_eff) begin
							done_d  = 1'b1;
							phase_d = PH_IDLE;
						end else if (gap_q == 20'd0) begin
							phase_d = PH_SETUP;
							if (cs_setup_q == 10'd0) begin
								phase_d  = PH_LOW;
								bit_d    = '0;
								frame_d  = '0;
								clkreg_d = 1'b0;
							end
						end else begin
							phase_d = PH_GAP;
						end
					end else begin
						bit_d    = bit_d + 4'd1;
						phase_d  = PH_LOW;
						clkreg_d = 1'b0;
					end
				end
			end
			PH_GAP: begin
				busy_d = 1'b1;
				tick_d = tick_inc;
				if (tick_inc >= gap_q) begin
					phase_d = PH_SETUP;
					tick_d  = '0;
					if (cs_setup_q == 10'd0) begin
						phase_d  = PH_LOW;
						bit_d    = '0;
						frame_d  = '0;
						clkreg_d = 1'b0;
					end
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	// restoring divider step
	assign trial    = {rem_q, quo_q[15]};
	assign trial_ge = trial >= {1'b0, div_d_q};
	assign div_last = div_cnt_q == 4'd15;

	always_comb begin
		ctl_d    = ctl_q;
		in_ready = 1'b0;
		load_out = 1'b0;
		unique case (ctl_q)
			CTL_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) ctl_d = done_d ? CTL_DIV : CTL_OUT;
			end
			CTL_DIV: begin
				if (div_last) ctl_d = CTL_OUT;
			end
			CTL_OUT: begin
				load_out = !out_valid_q || out_ready;
				if (load_out) ctl_d = CTL_IDLE;
			end
			default: ctl_d = CTL_IDLE;
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_q <= CTL_IDLE;
		else         ctl_q <= ctl_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			tick_q    <= '0;
			bit_q     <= '0;
			frame_q   <= '0;
			sum_q     <= '0;
			samples_q <= '0;
			open_q    <= 1'b0;
			clkreg_q  <= 1'b0;
			held_q    <= '0;
		end else begin
			if (accept) begin
				phase_q   <= phase_d;
				tick_q    <= tick_d;
				bit_q     <= bit_d;
				frame_q   <= frame_d;
				sum_q     <= sum_d;
				samples_q <= samples_d;
				open_q    <= open_d;
				clkreg_q  <= clkreg_d;
			end
			if (ctl_q == CTL_DIV && div_last) begin
				held_q <= (|{quo_q[14:11], trial_ge & 1'b0}) ? CodeMax :
				          {quo_q[10:0], trial_ge};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sel_q      <= sel_d;
			clk_lvl_q  <= clk_lvl_d;
			done_q     <= done_d;
			busy_q     <= busy_d;
			res_open_q <= open_d;
			quo_q      <= sum_d;
			rem_q      <= '0;
			div_d_q    <= n_eff;
			div_cnt_q  <= '0;
		end else if (ctl_q == CTL_DIV) begin
			rem_q     <= trial_ge ? 5'(trial - {1'b0, div_d_q}) : trial[4:0];
			quo_q     <= {quo_q[14:0], trial_ge};
			div_cnt_q <= div_cnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)        out_valid_q <= 1'b0;
		else if (load_out)  out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.select_n         <= sel_q;
			out_q.clock_level      <= clk_lvl_q;
			out_q.done_res         <= done_q;
			out_q.temperature_code <= held_q;
			out_q.open_sensor      <= res_open_q;
			out_q.busy_res         <= busy_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.done_res |-> out_data.busy_res)
		else $error("done result outside a reading");

	a_select_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.select_n |-> out_data.busy_res)
		else $error("chip select low while not busy");

	a_done_divides: assert property (@(posedge clk) disable iff (!arst_n)
		accept && done_d |=> ctl_q == CTL_DIV)
		else $error("closing tick skipped the divider");

	a_divisor_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_q == CTL_DIV |-> div_d_q != 5'd0 && div_d_q <= MaxSamples)
		else $error("divisor out of range");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_q == CTL_DIV |=> !(ctl_q == CTL_IDLE && $past(div_cnt_q) != 4'd15))
		else $error("divider left early");

endmodule
